// ===== design/wsd_pkg.sv =====
`default_nettype none
package wsd_pkg;

  localparam logic [2:0] PH_HDR0   = 3'd0;
  localparam logic [2:0] PH_HDR1   = 3'd1;
  localparam logic [2:0] PH_EXTLEN = 3'd2;
  localparam logic [2:0] PH_MASK   = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_DEAD   = 3'd5;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [6:0] LEN_EXT16 = 7'h7E;
  localparam logic [6:0] LEN_EXT64 = 7'h7F;

  localparam logic [2:0] EXT16_BYTES_M1 = 3'd1;
  localparam logic [2:0] EXT64_BYTES_M1 = 3'd7;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [3:0] opcode;
    logic       compressed;
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       dead;
    logic [2:0] phase;
  } status_t;

endpackage
`default_nettype wire

// ===== design/wsd_in_stage.sv =====
`default_nettype none
module wsd_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  input  wire logic       take,
  output logic            full,
  output logic [7:0]      byte_q
);

  logic accept;

  assign in_stall = full && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q <= rx_byte;
    end
  end

endmodule
`default_nettype wire

// ===== design/wsd_parser.sv =====
`default_nettype none
module wsd_parser
  import wsd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] b,
  output res_t            res,
  output status_t         status
);

  logic [2:0]  phase, phase_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic        frame_compressed, frame_compressed_next;
  logic        frame_masked, frame_masked_next;
  logic [63:0] length_left, length_left_next;
  logic [2:0]  field_bytes_left, field_bytes_left_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  key_index, key_index_next;
  logic        error_seen, error_seen_next;

  logic [63:0] len_ext;
  logic [63:0] len_hdr;
  logic [7:0]  keyb;
  logic        is_last;

  assign len_ext = {length_left[55:0], b};
  assign len_hdr = {57'd0, b[6:0]};
  assign is_last = (length_left == 64'd1);

  always_comb begin
    case (key_index)
      2'd0:    keyb = mask_key[31:24];
      2'd1:    keyb = mask_key[23:16];
      2'd2:    keyb = mask_key[15:8];
      default: keyb = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next            = phase;
    frame_opcode_next     = frame_opcode;
    frame_compressed_next = frame_compressed;
    frame_masked_next     = frame_masked;
    length_left_next      = length_left;
    field_bytes_left_next = field_bytes_left;
    mask_key_next         = mask_key;
    key_index_next        = key_index;
    error_seen_next       = error_seen;
    res.valid      = 1'b0;
    res.kind       = KIND_DATA;
    res.opcode     = frame_opcode;
    res.compressed = frame_compressed;
    res.data       = 8'd0;
    res.last       = 1'b1;

    if (step && !error_seen) begin
      case (phase)
        PH_HDR0: begin
          frame_opcode_next     = b[3:0];
          frame_compressed_next = b[6];
          if (!b[7] || b[3:0] == 4'd0) begin
            error_seen_next = 1'b1;
            phase_next      = PH_DEAD;
            res.valid       = 1'b1;
            res.kind        = KIND_ERROR;
            res.opcode      = b[3:0];
            res.compressed  = b[6];
          end else begin
            phase_next = PH_HDR1;
          end
        end
        PH_HDR1: begin
          frame_masked_next = b[7];
          mask_key_next     = 32'd0;
          key_index_next    = 2'd0;
          length_left_next  = 64'd0;
          if (b[6:0] == LEN_EXT16) begin
            field_bytes_left_next = EXT16_BYTES_M1;
            phase_next            = PH_EXTLEN;
          end else if (b[6:0] == LEN_EXT64) begin
            field_bytes_left_next = EXT64_BYTES_M1;
            phase_next            = PH_EXTLEN;
          end else begin
            length_left_next = len_hdr;
            if (b[7]) begin
              phase_next = PH_MASK;
            end else if (b[6:0] == 7'd0) begin
              phase_next = PH_HDR0;
              res.valid  = 1'b1;
              res.kind   = KIND_EMPTY;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_EXTLEN: begin
          length_left_next = len_ext;
          if (field_bytes_left == 3'd0) begin
            key_index_next = 2'd0;
            if (frame_masked) begin
              phase_next = PH_MASK;
            end else if (len_ext == 64'd0) begin
              phase_next = PH_HDR0;
              res.valid  = 1'b1;
              res.kind   = KIND_EMPTY;
            end else begin
              phase_next = PH_DATA;
            end
          end else begin
            field_bytes_left_next = field_bytes_left - 3'd1;
          end
        end
        PH_MASK: begin
          mask_key_next = {mask_key[23:0], b};
          if (key_index == 2'd3) begin
            key_index_next = 2'd0;
            if (length_left == 64'd0) begin
              phase_next = PH_HDR0;
              res.valid  = 1'b1;
              res.kind   = KIND_EMPTY;
            end else begin
              phase_next = PH_DATA;
            end
          end else begin
            key_index_next = key_index + 2'd1;
          end
        end
        PH_DATA: begin
          key_index_next   = key_index + 2'd1;
          length_left_next = length_left - 64'd1;
          res.valid        = 1'b1;
          res.kind         = KIND_DATA;
          res.data         = b ^ keyb;
          res.last         = is_last;
          if (is_last) begin
            phase_next = PH_HDR0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HDR0;
      frame_opcode     <= 4'd0;
      frame_compressed <= 1'b0;
      frame_masked     <= 1'b0;
      length_left      <= 64'd0;
      field_bytes_left <= 3'd0;
      mask_key         <= 32'd0;
      key_index        <= 2'd0;
      error_seen       <= 1'b0;
    end else begin
      phase            <= phase_next;
      frame_opcode     <= frame_opcode_next;
      frame_compressed <= frame_compressed_next;
      frame_masked     <= frame_masked_next;
      length_left      <= length_left_next;
      field_bytes_left <= field_bytes_left_next;
      mask_key         <= mask_key_next;
      key_index        <= key_index_next;
      error_seen       <= error_seen_next;
    end
  end

  assign status.dead  = error_seen;
  assign status.phase = phase;

endmodule
`default_nettype wire

// ===== design/wsd_out_stage.sv =====
`default_nettype none
module wsd_out_stage
  import wsd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire res_t  res,
  output logic       can_load,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic [1:0] kind,
  output logic [3:0] opcode,
  output logic       compressed,
  output logic [7:0] data,
  output logic       last
);

  assign can_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && res.valid) begin
      kind       <= res.kind;
      opcode     <= res.opcode;
      compressed <= res.compressed;
      data       <= res.data;
      last       <= res.last;
    end
  end

endmodule
`default_nettype wire

// ===== design/websocket_frame_deframer.sv =====
// flow: a byte accepted into the input stage is parsed when that stage steps, and its
//   result is registered in the output stage; a held output stall delays both steps
// throughput: one byte per cycle while the output is not stalled, set by the header parser and
//   the 64-bit length countdown between the input and result registers
// reset: synchronous active-high rst returns the parser to await header byte zero
//   and clears all frame state, the error flag and both stage valids
`default_nettype none
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      kind,
  output logic [3:0]      opcode,
  output logic            compressed,
  output logic [7:0]      data,
  output logic            last
);

  logic       full;
  logic [7:0] byte_q;
  logic       can_load;
  logic       step;
  res_t       res;
  status_t    status;

  assign step = full && can_load;

  wsd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .take     (step),
    .full     (full),
    .byte_q   (byte_q)
  );

  wsd_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .b      (byte_q),
    .res    (res),
    .status (status)
  );

  wsd_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .opcode     (opcode),
    .compressed (compressed),
    .data       (data),
    .last       (last)
  );

`ifndef NO_ASSERTIONS
  a_nonpayload_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> last && data == 8'd0)
    else $error("empty or error result without last or with data");

  a_error_dead: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERROR |-> status.dead && status.phase == PH_DEAD)
    else $error("error result while parser is not dead");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> full && out_valid && out_stall)
    else $error("input stalled without a full input stage and blocked output");

  a_dead_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(status.dead) && !$past(rst) |-> !res.valid)
    else $error("result produced after protocol error");
`endif

endmodule
`default_nettype wire

// ===== sim/websocket_frame_deframer_tb.sv =====
`default_nettype none
module websocket_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wsd_pkg::*;

  localparam int STREAM_ITEMS   = 1320;
  localparam int TAIL_ITEMS     = 150;
  localparam int PAUSE_AT       = 300;
  localparam int HOLD_START     = 900;
  localparam int HOLD_CYCLES    = 160;
  localparam int MODE_PERIOD    = 100;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 1500;

  localparam logic [1:0] FORM_SHORT = 2'd0;
  localparam logic [1:0] FORM_EXT16 = 2'd1;
  localparam logic [1:0] FORM_EXT64 = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] opcode;
    logic       compressed;
    logic [7:0] data;
    logic       last;
  } frame_out_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] kind;
  logic [3:0] opcode;
  logic       compressed;
  logic [7:0] data;
  logic       last;

  logic [7:0] rx_stream[$];
  frame_out_t predicted_results[$];
  int         mismatches = 0;

  // parser state mirrored by the predictor
  logic [2:0]  p_phase = PH_HDR0;
  logic [3:0]  p_opcode = 4'd0;
  logic        p_rsv1 = 1'b0;
  logic        p_masked = 1'b0;
  logic [63:0] p_left = 64'd0;
  logic [2:0]  p_ext_left = 3'd0;
  logic [31:0] p_key = 32'd0;
  logic [1:0]  p_key_idx = 2'd0;
  logic        p_dead = 1'b0;

  int hold_cnt = 0;

  websocket_frame_deframer u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .opcode     (opcode),
    .compressed (compressed),
    .data       (data),
    .last       (last)
  );

  always #5 clk = ~clk;

  task automatic put_byte(input logic [7:0] v);
    rx_stream = {rx_stream, v};
  endtask

  function automatic logic header_end();
    p_key_idx = 2'd0;
    if (p_left == 64'd0) begin
      p_phase = PH_HDR0;
      return 1'b1;
    end
    p_phase = PH_DATA;
    return 1'b0;
  endfunction

  function automatic logic length_end();
    if (p_masked) begin
      p_phase = PH_MASK;
      p_key_idx = 2'd0;
      return 1'b0;
    end
    return header_end();
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    frame_out_t r;
    logic       emit;
    logic       empty;
    int         sh;
    r = '0;
    emit = 1'b0;
    empty = 1'b0;
    if (!p_dead) begin
      case (p_phase)
        PH_HDR0: begin
          p_opcode = b[3:0];
          p_rsv1 = b[6];
          if (!b[7] || b[3:0] == 4'd0) begin
            p_dead = 1'b1;
            p_phase = PH_DEAD;
            r.kind = KIND_ERROR;
            r.last = 1'b1;
            emit = 1'b1;
          end else begin
            p_phase = PH_HDR1;
          end
        end
        PH_HDR1: begin
          p_masked = b[7];
          p_key = 32'd0;
          p_key_idx = 2'd0;
          p_left = 64'd0;
          if (b[6:0] == LEN_EXT16) begin
            p_ext_left = EXT16_BYTES_M1;
            p_phase = PH_EXTLEN;
          end else if (b[6:0] == LEN_EXT64) begin
            p_ext_left = EXT64_BYTES_M1;
            p_phase = PH_EXTLEN;
          end else begin
            p_left = 64'(b[6:0]);
            empty = length_end();
          end
        end
        PH_EXTLEN: begin
          p_left = {p_left[55:0], b};
          if (p_ext_left == 3'd0) empty = length_end();
          else p_ext_left = p_ext_left - 3'd1;
        end
        PH_MASK: begin
          p_key = {p_key[23:0], b};
          if (p_key_idx == 2'd3) empty = header_end();
          else p_key_idx = p_key_idx + 2'd1;
        end
        PH_DATA: begin
          sh = 24 - 8 * int'(p_key_idx);
          p_key_idx = p_key_idx + 2'd1;
          p_left = p_left - 64'd1;
          r.kind = KIND_DATA;
          r.data = b ^ 8'(p_key >> sh);
          r.last = (p_left == 64'd0);
          if (p_left == 64'd0) p_phase = PH_HDR0;
          emit = 1'b1;
        end
        default: ;
      endcase
    end
    if (empty) begin
      r.kind = KIND_EMPTY;
      r.last = 1'b1;
      emit = 1'b1;
    end
    if (emit) begin
      r.opcode = p_opcode;
      r.compressed = p_rsv1;
      predicted_results = {predicted_results, r};
    end
  endtask

  task automatic add_frame(input logic [7:0] hdr0, input logic masked, input logic [1:0] form,
                           input logic [63:0] len, input logic [31:0] key,
                           input int unsigned n_payload);
    byte_queue_push: begin
      put_byte(hdr0);
      case (form)
        FORM_EXT16: begin
          put_byte({masked, LEN_EXT16});
          put_byte(len[15:8]);
          put_byte(len[7:0]);
        end
        FORM_EXT64: begin
          put_byte({masked, LEN_EXT64});
          for (int i = 7; i >= 0; i--) put_byte(len[8*i +: 8]);
        end
        default: put_byte({masked, len[6:0]});
      endcase
      if (masked) for (int i = 3; i >= 0; i--) put_byte(key[8*i +: 8]);
      for (int unsigned i = 0; i < n_payload; i++) put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // driver: predicts on every accepted transaction, then loads the next byte
  int  accepted = 0;
  int  send_gap = 0;
  int  send_mode_cnt = 0;
  bit  send_mode = 1'b1;
  bit  pause_done = 1'b0;
  bit  send_tail;

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      deframe_byte(rx_byte);
      accepted++;
    end
    send_mode_cnt++;
    if (send_mode_cnt == MODE_PERIOD) begin
      send_mode_cnt = 0;
      send_mode = ($urandom_range(0, 2) != 0);
    end
    send_tail = (rx_stream.size() < TAIL_ITEMS);
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (accepted == PAUSE_AT && !pause_done) begin
        in_valid <= 1'b0;
        if (predicted_results.size() == 0) pause_done = 1'b1;
      end else if (rx_stream.size() > 0) begin
        if (hold_cnt == 0 && !send_tail && send_mode && $urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          send_gap = $urandom_range(0, 8);
        end else begin
          in_valid <= 1'b1;
          rx_byte <= rx_stream[0];
          rx_stream.delete(0);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: random bursts plus one long hold-off
  int  rx_cycle = 0;
  int  stall_left = 0;
  int  stall_mode_cnt = 0;
  bit  stall_mode = 1'b1;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    rx_cycle++;
    stall_mode_cnt++;
    if (stall_mode_cnt == MODE_PERIOD) begin
      stall_mode_cnt = 0;
      stall_mode = ($urandom_range(0, 2) != 0);
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && rx_cycle >= HOLD_START) begin
      hold_done = 1'b1;
      hold_cnt <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (rx_stream.size() >= TAIL_ITEMS && stall_mode && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    frame_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d opcode %0h data %0h last %0b",
                 $time, kind, opcode, data, last);
        mismatches++;
      end else begin
        want = predicted_results[0];
        predicted_results.delete(0);
        check_field("kind", 8'(want.kind), 8'(kind));
        check_field("opcode", 8'(want.opcode), 8'(opcode));
        check_field("compressed", 8'(want.compressed), 8'(compressed));
        check_field("data", want.data, data);
        check_field("last", 8'(want.last), 8'(last));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("websocket_frame_deframer_tb: errors");
    $finish;
  end

  initial begin : stimulus
    logic [1:0]  form;
    logic [63:0] len;
    int unsigned pick;
    // directed frames
    add_frame(8'hBF, 1'b1, FORM_SHORT, 64'd3, 32'hFF00A55A, 3);
    add_frame(8'h82, 1'b0, FORM_SHORT, 64'd0, 32'h0, 0);
    add_frame(8'hC9, 1'b1, FORM_EXT16, 64'd0, 32'h12345678, 0);
    add_frame(8'hC8, 1'b0, FORM_EXT64, 64'd1, 32'h0, 1);
    // random well-formed frames
    while (rx_stream.size() < STREAM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        form = FORM_SHORT;
        len = ($urandom_range(0, 3) != 0) ? 64'($urandom_range(0, 12)) : 64'($urandom_range(0, 125));
      end else if (pick < 9) begin
        form = FORM_EXT16;
        len = ($urandom_range(0, 3) != 0) ? 64'($urandom_range(0, 40)) : 64'($urandom_range(250, 300));
      end else begin
        form = FORM_EXT64;
        len = 64'($urandom_range(0, 40));
      end
      add_frame({1'b1, 3'($urandom_range(0, 7)), 4'($urandom_range(1, 15))},
                1'($urandom_range(0, 1)), form, len, $urandom, int'(len));
    end
    // closing frame: a fragment error, a zero opcode or a huge length, any of which ends the stream
    pick = $urandom_range(0, 2);
    if (pick == 0) begin
      put_byte({1'b0, 7'($urandom_range(0, 127))});
    end else if (pick == 1) begin
      put_byte({1'b1, 3'($urandom_range(0, 7)), 4'd0});
    end else begin
      add_frame({1'b1, 3'($urandom_range(0, 7)), 4'($urandom_range(1, 15))},
                1'($urandom_range(0, 1)), FORM_EXT64, {1'b1, 31'($urandom), $urandom},
                $urandom, 20);
    end
    for (int i = 0; i < 8; i++) put_byte(8'($urandom_range(0, 255)));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (rx_stream.size() != 0 || in_valid) @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("websocket_frame_deframer_tb: clean");
    end else begin
      $display("websocket_frame_deframer_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
